/* rtl/iee_pkg.sv */
// Package with types, constants and codes shared by the expression evaluator.
`default_nettype none
package iee_pkg;
	localparam int OP_DEPTH = 32;
	localparam int VALUE_DEPTH = 32;
	localparam int OP_AW = $clog2(OP_DEPTH);
	localparam int VAL_AW = $clog2(VALUE_DEPTH);
	localparam int OP_CW = $clog2(OP_DEPTH + 1);
	localparam int VAL_CW = $clog2(VALUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_NUMBER = 3'd0,
		CMD_OPEN   = 3'd1,
		CMD_CLOSE  = 3'd2,
		CMD_OPER   = 3'd3,
		CMD_END    = 3'd4
	} cmd_t;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;
	localparam logic [2:0] PAREN_MARK = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_STACK = 2'd2;

	typedef enum logic [2:0] {
		AL_IDLE,
		AL_DIV,
		AL_POW_MUL,
		AL_POW_SQ,
		AL_DONE
	} alu_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_RDOP,
		S_RDWAIT,
		S_LOOP,
		S_RDVAL,
		S_RDWAIT2,
		S_ALU_GO,
		S_ALU_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [2:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div0;
	} alu_rsp_t;

	function automatic logic [1:0] prec_of(input logic [2:0] op);
		case (op)
			OP_POW: prec_of = 2'd2;
			OP_MUL, OP_DIV: prec_of = 2'd1;
			default: prec_of = 2'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* rtl/infix_expression_evaluator.sv */
// Top level of the two-stack infix expression evaluator.
// One token is taken at a time; ready is low while it is processed.
// A number or open paren is pushed straight away; a close paren or operator first reduces
// while the precedence rules call for it, each reduction running the arithmetic unit for
// add, subtract, multiply, divide or power. The end token reduces the whole stack and also
// waits while an earlier result is still held in the output register.
// Reset clears the stack counts, fault code and output valid; stack memories are not cleared.
`default_nettype none
module infix_expression_evaluator (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [2:0] command,
	input  wire logic [30:0] number_value,
	input  wire logic [2:0] operator_code,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0] status
);
	import iee_pkg::*;

	state_t st_q, st_d;
	logic [2:0] ops_mem [OP_DEPTH];
	logic [31:0] val_mem [VALUE_DEPTH];
	logic [OP_CW-1:0] opc_q;
	logic [VAL_CW-1:0] valc_q;
	logic [1:0] fault_q;
	logic [2:0] cmd_q, opin_q, top_q, rop_q;
	logic [30:0] num_q;
	logic [31:0] va_q, vb_q, vtop_q;
	alu_req_t areq;
	alu_rsp_t arsp;
	logic [31:0] ares;

	iee_alu u_alu (.clk, .arst_n, .req(areq), .a(va_q), .b(vb_q), .rsp(arsp), .res(ares));

	assign in_ready = (st_q == S_IDLE);
	assign areq.start = (st_q == S_ALU_GO);
	assign areq.op = rop_q;

	logic want_reduce;
	always_comb begin
		want_reduce = 1'b0;
		if (opc_q != '0) begin
			case (cmd_q)
				CMD_CLOSE: want_reduce = (top_q != PAREN_MARK);
				CMD_OPER: want_reduce = (top_q != PAREN_MARK) &&
					(prec_of(top_q) >= prec_of(opin_q));
				default: want_reduce = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		top_q <= ops_mem[opc_q[OP_AW-1:0] - OP_AW'(1)];
		vb_q <= val_mem[valc_q[VAL_AW-1:0] - VAL_AW'(1)];
		va_q <= val_mem[valc_q[VAL_AW-1:0] - VAL_AW'(2)];
		vtop_q <= val_mem[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			opc_q <= '0;
			valc_q <= '0;
			fault_q <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				S_IDLE: if (in_valid) begin
					cmd_q <= command;
					num_q <= number_value;
					opin_q <= operator_code;
				end
				S_DECIDE: begin
					case (cmd_q)
						CMD_NUMBER: begin
							if (valc_q >= VAL_CW'(VALUE_DEPTH)) begin
								if (fault_q == ST_OK) fault_q <= ST_STACK;
							end else begin
								val_mem[valc_q[VAL_AW-1:0]] <= {1'b0, num_q};
								valc_q <= valc_q + VAL_CW'(1);
							end
						end
						CMD_OPEN: begin
							if (opc_q >= OP_CW'(OP_DEPTH)) begin
								if (fault_q == ST_OK) fault_q <= ST_STACK;
							end else begin
								ops_mem[opc_q[OP_AW-1:0]] <= PAREN_MARK;
								opc_q <= opc_q + OP_CW'(1);
							end
						end
						CMD_OPER: if (opin_q > OP_POW && fault_q == ST_OK)
							fault_q <= ST_STACK;
						default: ;
					endcase
				end
				S_LOOP: begin
					if (want_reduce) begin
						opc_q <= opc_q - OP_CW'(1);
						rop_q <= top_q;
						if (top_q == PAREN_MARK) begin
							if (fault_q == ST_OK) fault_q <= ST_STACK;
						end else if (valc_q < VAL_CW'(2)) begin
							if (fault_q == ST_OK) fault_q <= ST_STACK;
						end
					end else begin
						case (cmd_q)
							CMD_CLOSE: begin
								if (opc_q == '0) begin
									if (fault_q == ST_OK) fault_q <= ST_STACK;
								end else opc_q <= opc_q - OP_CW'(1);
							end
							CMD_OPER: begin
								if (opc_q >= OP_CW'(OP_DEPTH)) begin
									if (fault_q == ST_OK) fault_q <= ST_STACK;
								end else begin
									ops_mem[opc_q[OP_AW-1:0]] <= opin_q;
									opc_q <= opc_q + OP_CW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				S_ALU_WAIT: if (arsp.done) begin
					val_mem[valc_q[VAL_AW-1:0] - VAL_AW'(2)] <= ares;
					valc_q <= valc_q - VAL_CW'(1);
					if (arsp.div0 && fault_q == ST_OK) fault_q <= ST_DIV0;
				end
				S_OUT: if (!out_valid) begin
					if (valc_q != VAL_CW'(1) || fault_q != ST_OK) begin
						result_value <= '0;
						status <= (fault_q != ST_OK) ? fault_q : ST_STACK;
					end else begin
						result_value <= vtop_q;
						status <= ST_OK;
					end
					out_valid <= 1'b1;
					opc_q <= '0;
					valc_q <= '0;
					fault_q <= ST_OK;
				end
				default: ;
			endcase
			if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (in_valid) st_d = S_DECIDE;
			S_DECIDE: begin
				case (cmd_q)
					CMD_CLOSE, CMD_END: st_d = S_RDOP;
					CMD_OPER: st_d = (opin_q > OP_POW) ? S_IDLE : S_RDOP;
					default: st_d = S_IDLE;
				endcase
			end
			S_RDOP: st_d = S_RDWAIT;
			S_RDWAIT: st_d = S_LOOP;
			S_LOOP: begin
				if (want_reduce) begin
					if (top_q == PAREN_MARK || valc_q < VAL_CW'(2)) st_d = S_RDOP;
					else st_d = S_RDVAL;
				end else if (cmd_q == CMD_END) st_d = S_OUT;
				else st_d = S_IDLE;
			end
			S_RDVAL: st_d = S_RDWAIT2;
			S_RDWAIT2: st_d = S_ALU_GO;
			S_ALU_GO: st_d = S_ALU_WAIT;
			S_ALU_WAIT: if (arsp.done) st_d = S_RDOP;
			S_OUT: if (!out_valid) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/iee_alu.sv */
// Shared iterative arithmetic unit: add, subtract, multiply, divide and power.
`default_nettype none
module iee_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire iee_pkg::alu_req_t req,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output iee_pkg::alu_rsp_t rsp,
	output logic [31:0] res
);
	import iee_pkg::*;

	alu_state_t st_q;
	logic [31:0] acc_q, sq_q, e_q, rem_q, mb_q;
	logic [5:0] cnt_q;
	logic neg_q, div0_q;
	logic [31:0] mul_x, mul_y, mul_p;
	logic [32:0] trial;

	assign mul_p = mul_x * mul_y;
	assign trial = {rem_q, acc_q[31]} - {1'b0, mb_q};

	always_comb begin
		mul_x = a;
		mul_y = b;
		case (st_q)
			AL_POW_MUL: begin
				mul_x = acc_q;
				mul_y = sq_q;
			end
			AL_POW_SQ: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			default: ;
		endcase
	end

	assign rsp.done = (st_q == AL_DONE);
	assign rsp.div0 = div0_q;
	assign res = neg_q ? 32'd0 - acc_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= AL_IDLE;
		end else begin
			case (st_q)
				AL_IDLE: begin
					if (req.start) begin
						neg_q <= 1'b0;
						div0_q <= 1'b0;
						case (req.op)
							OP_ADD: begin
								acc_q <= a + b;
								st_q <= AL_DONE;
							end
							OP_SUB: begin
								acc_q <= a - b;
								st_q <= AL_DONE;
							end
							OP_MUL: begin
								acc_q <= mul_p;
								st_q <= AL_DONE;
							end
							OP_DIV: begin
								if (b == 32'd0) begin
									acc_q <= 32'd0;
									div0_q <= 1'b1;
									st_q <= AL_DONE;
								end else begin
									acc_q <= a[31] ? 32'd0 - a : a;
									mb_q <= b[31] ? 32'd0 - b : b;
									neg_q <= a[31] ^ b[31];
									rem_q <= 32'd0;
									cnt_q <= 6'd32;
									st_q <= AL_DIV;
								end
							end
							default: begin
								if (b[31]) begin
									if (a == 32'd1) acc_q <= 32'd1;
									else if (a == 32'hFFFF_FFFF)
										acc_q <= b[0] ? 32'hFFFF_FFFF : 32'd1;
									else acc_q <= 32'd0;
									st_q <= AL_DONE;
								end else begin
									acc_q <= 32'd1;
									sq_q <= a;
									e_q <= b;
									st_q <= AL_POW_MUL;
								end
							end
						endcase
					end
				end
				AL_DIV: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						acc_q <= {acc_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], acc_q[31]};
						acc_q <= {acc_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) st_q <= AL_DONE;
				end
				AL_POW_MUL: begin
					if (e_q == 32'd0) begin
						st_q <= AL_DONE;
					end else begin
						if (e_q[0]) acc_q <= mul_p;
						st_q <= AL_POW_SQ;
					end
				end
				AL_POW_SQ: begin
					sq_q <= mul_p;
					e_q <= {1'b0, e_q[31:1]};
					st_q <= AL_POW_MUL;
				end
				AL_DONE: st_q <= AL_IDLE;
				default: st_q <= AL_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/iee_checker.sv */
// Port-level assertions for the expression evaluator, bound to the top level.
`default_nettype none
module iee_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic [31:0] result_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("result dropped while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> result_value == 32'd0)
		else $error("faulted result not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind infix_expression_evaluator iee_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .status, .result_value);
`default_nettype wire
